// ===== hdl/tgbp_pkg.sv =====
// ----------------------------------------------------------------------------
// tgbp_pkg
// Shared types and constants of the tagged geometric-history branch predictor.
// ----------------------------------------------------------------------------
package tgbp_pkg;

  // Result code for "no tagged table": base bimodal
  localparam logic [3:0] NO_TABLE = 4'd8;

  // Opcodes carried on in_tuser
  localparam logic OP_PREDICT = 1'b0;
  localparam logic OP_UPDATE  = 1'b1;

  // Geometric history lengths, one per tagged table
  localparam int GEO_LEN [8] = '{4, 7, 12, 20, 34, 58, 99, 168};

  // Per-table index scramble multiplier
  localparam logic [63:0] TABLE_MULT = 64'd2654435761;

  // Counter value of a freshly allocated entry and of the base at reset
  localparam logic [1:0] CTR_WEAK_TAKEN = 2'd2;

  // Controller states, one-hot
  typedef enum logic [5:0] {
    ST_CLEAR   = 6'b000001,
    ST_IDLE    = 6'b000010,
    ST_READ    = 6'b000100,
    ST_EVAL    = 6'b001000,
    ST_SWEEP   = 6'b010000,
    ST_SW_END  = 6'b100000
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture an input beat
    logic commit;    // write back, load output register
    logic clr_step;  // clearing pass: write one entry
    logic sw_step;   // decay sweep: read next entry
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_done;    // clearing pass at its last entry
    logic sw_last;     // sweep reading its last entry
    logic decay_fire;  // this update ends a decay period
  } stat_t;

  // Saturating 2-bit counter step
  function automatic logic [1:0] bump(input logic [1:0] c, input logic up);
    logic [1:0] r;
    r = c;
    if (up) begin
      if (c != 2'd3) r = c + 2'd1;
    end else begin
      if (c != 2'd0) r = c - 2'd1;
    end
    return r;
  endfunction

endpackage

// ===== hdl/tgbp_ram.sv =====
// ----------------------------------------------------------------------------
// tgbp_ram
// Generic memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tgbp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/tgbp_ctrl.sv =====
// ----------------------------------------------------------------------------
// tgbp_ctrl
// Sequencer: clearing pass, beat capture, evaluate/commit, decay sweep.
// ----------------------------------------------------------------------------
module tgbp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  output tgbp_pkg::cmd_t cmd,
  input  tgbp_pkg::stat_t stat
);
  import tgbp_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   can_commit;

  assign can_commit = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_EVAL;
      ST_EVAL: begin
        if (can_commit) begin
          cmd.commit = 1'b1;
          state_nxt  = stat.decay_fire ? ST_SWEEP : ST_IDLE;
        end
      end
      ST_SWEEP: begin
        cmd.sw_step = 1'b1;
        if (stat.sw_last) state_nxt = ST_SW_END;
      end
      ST_SW_END: state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  // output beat held until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit)      out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hdl/tgbp_dp.sv =====
// ----------------------------------------------------------------------------
// tgbp_dp
// Datapath: table memories, history, folds, provider search, training,
// allocation, decay tick, latches, configuration registers.
// ----------------------------------------------------------------------------
module tgbp_dp #(
  parameter int TAGGED_TABLES    = 8,
  parameter int BASE_INDEX_BITS  = 13,
  parameter int TABLE_INDEX_BITS = 12,
  parameter int TAG_WIDTH        = 12,
  parameter int HISTORY_LENGTH   = 168
) (
  input  logic            clk,
  input  logic            rst_n,
  input  tgbp_pkg::cmd_t  cmd,
  output tgbp_pkg::stat_t stat,
  input  logic            in_opcode,
  input  logic [63:0]     in_pc,
  input  logic            in_taken,
  input  logic            in_pred_taken,
  output logic            out_prediction,
  output logic [3:0]      out_provider,
  output logic [3:0]      out_alternate,
  input  logic            cfg_we,
  input  logic            cfg_sel,
  input  logic [31:0]     cfg_wdata,
  output logic [31:0]     cfg_rdata
);
  import tgbp_pkg::*;

  localparam int T   = TAGGED_TABLES;
  localparam int BIB = BASE_INDEX_BITS;
  localparam int TIB = TABLE_INDEX_BITS;
  localparam int TW  = TAG_WIDTH;
  localparam int HL  = HISTORY_LENGTH;
  localparam int EW  = TW + 4;
  localparam int CB  = (BIB > TIB) ? BIB : TIB;

  // configuration
  logic [17:0] period_r;
  logic [3:0]  max_alloc_r;

  // captured beat
  logic        op_r, taken_r, pt_r;
  logic [31:0] pc32_r;

  logic [HL-1:0] hist_r;
  logic [17:0]   tick_r, tick_inc;
  logic [3:0]    prov_lat_r, alt_lat_r;

  logic [CB-1:0]  clr_cnt_r;
  logic [TIB-1:0] sw_cnt_r, pend_addr_r;
  logic           pend_r;

  // table views
  logic [TIB-1:0] slot   [T];
  logic [TW-1:0]  tag_c  [T];
  logic [EW-1:0]  rd_ent [T];
  logic [EW-1:0]  wr_ent [T];
  logic           wr_en  [T];
  logic [T-1:0]   hit, alloc;

  logic [1:0]     base_rd, base_wd;
  logic           base_we;
  logic [BIB-1:0] base_waddr;
  logic           base_dir;

  logic [3:0] p_sel, a_sel, sprov, salt;
  logic       pdir, adir, sp_useful0, pred;
  logic       mis, prov_ok;
  logic [3:0] made;

  assign tick_inc = tick_r + 18'd1;

  assign stat.clr_done   = &clr_cnt_r;
  assign stat.sw_last    = &sw_cnt_r;
  assign stat.decay_fire = (op_r == OP_UPDATE) && (tick_inc >= period_r);

  assign base_dir = base_rd[1];

  // per-table fold, index, tag and memory
  for (genvar t = 0; t < T; t++) begin : g_tbl
    localparam int L = (GEO_LEN[t] > HL) ? HL : GEO_LEN[t];
    localparam logic [63:0] SCR = 64'(t) * TABLE_MULT;
    logic [TIB-1:0] fi;
    logic [TW-1:0]  ft;
    logic [63:0]    pc_ext;
    logic [TIB-1:0] raddr, waddr;

    always_comb begin
      fi = '0;
      ft = '0;
      for (int i = 0; i < L; i++) begin
        fi[i % TIB] = fi[i % TIB] ^ hist_r[i];
        ft[i % TW]  = ft[i % TW]  ^ hist_r[i];
      end
    end

    assign pc_ext   = {32'd0, pc32_r};
    assign slot[t]  = pc32_r[TIB-1:0] ^ (fi + SCR[TIB-1:0]);
    assign tag_c[t] = ft ^ pc_ext[TIB +: TW];
    assign hit[t]   = (rd_ent[t][EW-1:4] == tag_c[t]);

    assign raddr = cmd.sw_step ? sw_cnt_r : slot[t];

    // write port: clear, then sweep, then commit
    always_comb begin
      if (cmd.clr_step)  waddr = clr_cnt_r[TIB-1:0];
      else if (pend_r)   waddr = pend_addr_r;
      else               waddr = slot[t];
    end

    tgbp_ram #(.WIDTH(EW), .DEPTH(1 << TIB)) u_ram (
      .clk   (clk),
      .we    (wr_en[t]),
      .waddr (waddr),
      .wdata (wr_ent[t]),
      .raddr (raddr),
      .rdata (rd_ent[t])
    );
  end

  tgbp_ram #(.WIDTH(2), .DEPTH(1 << BIB)) u_base (
    .clk   (clk),
    .we    (base_we),
    .waddr (base_waddr),
    .wdata (base_wd),
    .raddr (pc32_r[BIB-1:0]),
    .rdata (base_rd)
  );

  // provider / alternate search, longest history first
  always_comb begin
    p_sel = NO_TABLE;
    a_sel = NO_TABLE;
    for (int t = T - 1; t >= 0; t--) begin
      if (hit[t]) begin
        if (p_sel == NO_TABLE)      p_sel = 4'(t);
        else if (a_sel == NO_TABLE) a_sel = 4'(t);
      end
    end
  end

  // the pair in use: fresh for predict, latched for update
  assign sprov = (op_r == OP_UPDATE) ? prov_lat_r : p_sel;
  assign salt  = (op_r == OP_UPDATE) ? alt_lat_r  : a_sel;

  always_comb begin
    pdir       = base_dir;
    adir       = base_dir;
    sp_useful0 = 1'b0;
    for (int t = 0; t < T; t++) begin
      if (sprov == 4'(t)) begin
        pdir       = rd_ent[t][3];
        sp_useful0 = (rd_ent[t][1:0] == 2'd0);
      end
      if (salt == 4'(t)) adir = rd_ent[t][3];
    end
  end

  assign prov_ok = (sprov < 4'(T));
  assign pred    = prov_ok ? (sp_useful0 ? adir : pdir) : base_dir;
  assign mis     = (taken_r != pt_r);

  // allocation on a misprediction, in longer tables
  always_comb begin
    made  = '0;
    alloc = '0;
    for (int t = 0; t < T; t++) begin
      if (mis && (!prov_ok || 4'(t) > sprov) && (made < max_alloc_r) &&
          !hit[t] && (rd_ent[t][1:0] == 2'd0)) begin
        alloc[t] = 1'b1;
        made     = made + 4'd1;
      end
    end
  end

  // write data for the tables
  always_comb begin
    for (int t = 0; t < T; t++) begin
      wr_en[t]  = 1'b0;
      wr_ent[t] = rd_ent[t];
      if (cmd.clr_step) begin
        wr_en[t]  = 1'b1;
        wr_ent[t] = '0;
      end else if (pend_r) begin
        wr_en[t]  = 1'b1;
        wr_ent[t] = {rd_ent[t][EW-1:2], 1'b0, rd_ent[t][1]};
      end else if (cmd.commit && op_r == OP_UPDATE) begin
        if (sprov == 4'(t)) begin
          wr_en[t]       = 1'b1;
          wr_ent[t][3:2] = bump(rd_ent[t][3:2], taken_r);
          if (pdir != adir)
            wr_ent[t][1:0] = bump(rd_ent[t][1:0], taken_r == pdir);
        end else if (alloc[t]) begin
          wr_en[t]       = 1'b1;
          wr_ent[t][EW-1:4] = tag_c[t];
          wr_ent[t][3:2]    = CTR_WEAK_TAKEN;
        end
      end
    end
  end

  // base table write
  always_comb begin
    if (cmd.clr_step) begin
      base_we    = 1'b1;
      base_waddr = clr_cnt_r[BIB-1:0];
      base_wd    = CTR_WEAK_TAKEN;
    end else begin
      base_we    = cmd.commit && (op_r == OP_UPDATE);
      base_waddr = pc32_r[BIB-1:0];
      base_wd    = bump(base_rd, taken_r);
    end
  end

  // captured beat, no reset
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_opcode;
      pc32_r  <= in_pc[33:2];
      taken_r <= in_taken;
      pt_r    <= in_pred_taken;
    end
    if (cmd.sw_step) pend_addr_r <= sw_cnt_r;
    if (cmd.commit) begin
      out_prediction <= (op_r == OP_UPDATE) ? 1'b0 : pred;
      out_provider   <= sprov;
      out_alternate  <= salt;
    end
  end

  // control and predictor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= 18'd256000;
      max_alloc_r <= 4'd2;
      hist_r      <= '0;
      tick_r      <= '0;
      prov_lat_r  <= NO_TABLE;
      alt_lat_r   <= NO_TABLE;
      clr_cnt_r   <= '0;
      sw_cnt_r    <= '0;
      pend_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_sel) max_alloc_r <= cfg_wdata[3:0];
        else         period_r    <= cfg_wdata[17:0];
      end
      if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cmd.sw_step)  sw_cnt_r  <= sw_cnt_r + 1'b1;
      pend_r <= cmd.sw_step;
      if (cmd.commit) begin
        if (op_r == OP_UPDATE) begin
          tick_r <= stat.decay_fire ? 18'd0 : tick_inc;
          hist_r <= {hist_r[HL-2:0], taken_r};
        end else begin
          prov_lat_r <= p_sel;
          alt_lat_r  <= a_sel;
        end
      end
    end
  end

  assign cfg_rdata = cfg_sel ? {28'd0, max_alloc_r} : {14'd0, period_r};

endmodule

// ===== hdl/tagged_geometric_branch_predictor.sv =====
// ----------------------------------------------------------------------------
// tagged_geometric_branch_predictor
// Branch predictor with a bimodal base and tagged geometric-history tables.
//
//   channel  dir  fields
//   in_      in   tuser: opcode; tdata: pc, taken, predicted_taken
//   out_     out  tdata: prediction, provider_table, alternate_table
//   cfg      in   APB, 0x0 decay_period, 0x4 max_allocations
//
// A beat passes through capture, table read (one read port per memory),
// evaluate and write back before the next beat is taken. Its result becomes
// valid in the same cycle that in_tready is high again, unless a sweep follows.
// After reset a clearing pass over 2^max(BASE_INDEX_BITS, TABLE_INDEX_BITS)
// addresses (8192 by default) fills the memories before in_tready rises.
// An update that ends a decay period is followed by a useful-count sweep of
// all 2^TABLE_INDEX_BITS entries. A stalled output holds the block in write back.
// ----------------------------------------------------------------------------
module tagged_geometric_branch_predictor #(
  parameter int TAGGED_TABLES    = 8,
  parameter int BASE_INDEX_BITS  = 13,
  parameter int TABLE_INDEX_BITS = 12,
  parameter int TAG_WIDTH        = 12,
  parameter int HISTORY_LENGTH   = 168
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // pc[63:0], taken, predicted_taken, zero pad
  input  logic        in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // prediction, provider_table[3:0],
                                  // alternate_table[3:0], zero pad
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tgbp_pkg::*;

  cmd_t       cmd;
  stat_t      stat;
  logic       pred;
  logic [3:0] prov, alt;

  assign pready    = 1'b1;
  assign out_tdata = {7'd0, alt, prov, pred};

  tgbp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  tgbp_dp #(
    .TAGGED_TABLES    (TAGGED_TABLES),
    .BASE_INDEX_BITS  (BASE_INDEX_BITS),
    .TABLE_INDEX_BITS (TABLE_INDEX_BITS),
    .TAG_WIDTH        (TAG_WIDTH),
    .HISTORY_LENGTH   (HISTORY_LENGTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_opcode      (in_tuser),
    .in_pc          (in_tdata[63:0]),
    .in_taken       (in_tdata[64]),
    .in_pred_taken  (in_tdata[65]),
    .out_prediction (pred),
    .out_provider   (prov),
    .out_alternate  (alt),
    .cfg_we         (psel && penable && pwrite),
    .cfg_sel        (paddr[2]),
    .cfg_wdata      (pwdata),
    .cfg_rdata      (prdata)
  );

endmodule
